FILE: rtl/core/cis2d_pkg.sv
package cis2d_pkg;

  localparam int DEF_NUM_BODIES   = 64;
  localparam int DEF_NUM_CONTACTS = 64;
  localparam int DEF_FRAC_BITS    = 16;

  localparam logic [2:0] CMD_LOAD_MASS  = 3'd0;
  localparam logic [2:0] CMD_LOAD_MOT   = 3'd1;
  localparam logic [2:0] CMD_CLEAR      = 3'd2;
  localparam logic [2:0] CMD_SOLVE      = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  localparam logic [1:0] REG_TIME_STEP  = 2'd0;

  localparam logic [30:0] TIME_STEP_RESET = 31'd1092;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return SMAX;
    else if (v < -33'sd2147483648) return SMIN;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33(33'(a) - 33'(b));
  endfunction

  function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
    return sat33(-33'(a));
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return SMAX;
    else if (v < -64'sd2147483648) return SMIN;
    else return v[31:0];
  endfunction

endpackage

FILE: rtl/core/cis2d_div.sv
// Iterative signed divide: q = trunc(n / d), saturated, one quotient bit per cycle.
module cis2d_div
  import cis2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  logic [63:0] rem, q;
  logic [31:0] dmag;
  logic        neg, busy;
  logic [6:0]  cnt;
  logic [64:0] trial;
  logic [63:0] qs;
  logic signed [63:0] qsg;

  assign trial = {rem[63:0], q[63]} - {33'd0, dmag};
  assign qsg = neg ? -$signed(q) : $signed(q);
  assign qs = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        neg <= num[63] ^ den[31];
        q <= num[63] ? 64'(-num) : 64'(num);
        dmag <= den[31] ? 32'(-den) : 32'(den);
        rem <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (!neg && qs[63]) quo = SMAX;
    else quo = sat64(qsg);
  end
endmodule

FILE: rtl/core/cis2d_sqrt.sv
// Iterative integer root of x << FRAC_BITS, two radicand bits per cycle.
module cis2d_sqrt
  import cis2d_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x,
  output logic               done,
  output logic signed [31:0] root
);
  logic [63:0] v, res, bitv, sum;
  logic        busy;

  assign sum = res + bitv;
  assign root = res[31] ? SMAX : $signed(res[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v <= (x <= 0) ? 64'd0 : (64'(x) << FRAC_BITS);
        res <= '0;
        bitv <= 64'd1 << 62;
        busy <= 1'b1;
      end else if (busy) begin
        if (bitv == 64'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (v >= sum) begin
            v <= v - sum;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end
endmodule

FILE: rtl/core/contact_impulse_solver_2d.sv
// channel  | signals                                      | direction
// request  | in_valid/in_ready, command..value_six        | in
// result   | out_valid/out_ready, pos_x..tangent_impulse  | out
// config   | psel/penable/pwrite/paddr/pwdata/prdata      | in/out
// One request at a time: each load, clear, read or solve gives one result; a
// solve runs the bit-serial divider per impulse, and the root too with friction,
// and a single body is written back as one body word instead of two.
// Reset is synchronous; after reset the slot impulses are cleared one slot at a
// time, with no request taken. A stalled result holds in the output register
// while the next request is taken and computed behind it.
module contact_impulse_solver_2d
  import cis2d_pkg::*;
#(
  parameter int NUM_BODIES   = DEF_NUM_BODIES,
  parameter int NUM_CONTACTS = DEF_NUM_CONTACTS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [5:0]         body_a,
  input  logic [5:0]         body_b,
  input  logic [5:0]         contact_slot,
  input  logic signed [31:0] value_one,
  input  logic signed [31:0] value_two,
  input  logic signed [31:0] value_three,
  input  logic signed [31:0] value_four,
  input  logic signed [31:0] value_five,
  input  logic signed [31:0] value_six,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] angle,
  output logic signed [31:0] speed_x,
  output logic signed [31:0] speed_y,
  output logic signed [31:0] spin,
  output logic [30:0]        normal_impulse,
  output logic signed [31:0] tangent_impulse
);
  localparam int BW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
  localparam int SW = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;
  localparam int NF = 11;

  // body fields
  localparam logic [3:0] F_PX = 4'd0, F_PY = 4'd1, F_AN = 4'd2, F_VX = 4'd3,
    F_VY = 4'd4, F_W = 4'd5, F_IM = 4'd6, F_II = 4'd7, F_FR = 4'd8,
    F_CX = 4'd9, F_CY = 4'd10;

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_RDA = 5'd2, S_RDB = 5'd3,
    S_RDW = 5'd4, S_CALC = 5'd5, S_DIV = 5'd6, S_SQRT = 5'd7, S_APPLY = 5'd8,
    S_WRB = 5'd9, S_OUTW = 5'd11, S_OUT = 5'd12,
    S_DIVW = 5'd13, S_SQW = 5'd14;

  logic [30:0] time_step;
  logic [4:0]  st;

  // body memory: one wide word per body
  logic [NF*32-1:0] bmem [NUM_BODIES];
  logic [NF*32-1:0] brd, bwd;
  logic [BW-1:0]    braddr, bwaddr;
  logic             bwe;
  logic [63:0]      smem [NUM_CONTACTS];
  logic [63:0]      srd, swd;
  logic [SW-1:0]    sraddr, swaddr;
  logic             swe;

  always_ff @(posedge clk) begin
    if (bwe) bmem[bwaddr] <= bwd;
    brd <= bmem[braddr];
  end
  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swd;
    srd <= smem[sraddr];
  end

  assign pready = 1'b1;
  assign prdata = {1'b0, time_step};
  always_ff @(posedge clk) begin
    if (rst) time_step <= TIME_STEP_RESET;
    else if (psel && penable && pwrite && paddr == REG_TIME_STEP) time_step <= pwdata[30:0];
  end

  logic [2:0]  cmd;
  logic [BW-1:0] ia, ib;
  logic [SW-1:0] is;
  logic signed [31:0] v1, v2, v3, v4, v5, v6;
  logic signed [31:0] ba [NF];
  logic signed [31:0] bb [NF];
  logic signed [31:0] sn, stg;
  logic [SW-1:0] clr_cnt;

  // sequenced arithmetic: step counter through a microprogram with one multiply each
  logic [6:0] step;
  logic signed [31:0] rax, ray, rbx, rby, svx, svy, tm, vn, ca, cb, kk, lam;
  logic signed [31:0] dx, dy, t0, t1, ix, iy, ig, nl, fr, maxf;
  logic signed [31:0] tcl;
  logic       phase_t; // 0 normal, 1 tangent
  logic       onb;     // applying to body B

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> FRAC_BITS);
  endfunction

  logic        dstart, ddone, qstart, qdone;
  logic signed [63:0] dnum;
  logic signed [31:0] dquo, qroot;
  assign dnum = -(64'(vn) <<< FRAC_BITS);

  cis2d_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(kk),
    .done(ddone), .quo(dquo));
  cis2d_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (.clk, .rst, .start(qstart),
    .x(t0), .done(qdone), .root(qroot));

  assign in_ready = (st == S_IDLE);

  logic signed [31:0] mul_a, mul_b, mp;
  logic signed [31:0] dts;
  assign dts = $signed({1'b0, time_step});
  assign mp = qmul(mul_a, mul_b);

  // per-step multiplier operands
  always_comb begin
    mul_a = '0; mul_b = '0;
    case (step)
      7'd0:  begin mul_a = ray; mul_b = ba[F_W]; end
      7'd1:  begin mul_a = rby; mul_b = bb[F_W]; end
      7'd2:  begin mul_a = rax; mul_b = ba[F_W]; end
      7'd3:  begin mul_a = rbx; mul_b = bb[F_W]; end
      7'd4:  begin mul_a = svx; mul_b = dx; end
      7'd5:  begin mul_a = svy; mul_b = dy; end
      7'd6:  begin mul_a = rax; mul_b = dy; end
      7'd7:  begin mul_a = ray; mul_b = dx; end
      7'd8:  begin mul_a = rbx; mul_b = dy; end
      7'd9:  begin mul_a = rby; mul_b = dx; end
      7'd10: begin mul_a = ca; mul_b = ca; end
      7'd11: begin mul_a = ba[F_II]; mul_b = t0; end
      7'd12: begin mul_a = cb; mul_b = cb; end
      7'd13: begin mul_a = bb[F_II]; mul_b = t1; end
      default: ;
    endcase
  end

  // apply micro steps
  logic [3:0] ap;
  logic signed [31:0] am_a, am_b, ap_m;
  logic signed [31:0] lsel, csel, imv, iiv;
  assign lsel = onb ? nl : lam;
  assign csel = onb ? cb : ca;
  assign imv  = onb ? bb[F_IM] : ba[F_IM];
  assign iiv  = onb ? bb[F_II] : ba[F_II];
  always_comb begin
    am_a = '0; am_b = '0;
    case (ap)
      4'd0: begin am_a = lsel; am_b = dx; end
      4'd1: begin am_a = t0;   am_b = imv; end
      4'd2: begin am_a = lsel; am_b = dy; end
      4'd3: begin am_a = t0;   am_b = imv; end
      4'd4: begin am_a = lsel; am_b = csel; end
      4'd5: begin am_a = t0;   am_b = iiv; end
      4'd6: begin am_a = ix;   am_b = dts; end
      4'd7: begin am_a = iy;   am_b = dts; end
      4'd8: begin am_a = ig;   am_b = dts; end
      default: ;
    endcase
  end
  assign ap_m = qmul(am_a, am_b);

  // friction clamp of the accumulated tangent impulse
  always_comb begin
    if (t0 > maxf) tcl = maxf;
    else if (t0 < qneg(maxf)) tcl = qneg(maxf);
    else tcl = t0;
  end

  logic samebody;
  assign samebody = (ia == ib);

  always_comb begin
    bwd = '0;
    for (int i = 0; i < NF; i++) bwd[i*32 +: 32] = ba[i];
    swd = {stg, sn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      bwe <= 1'b0;
      swe <= 1'b0;
      dstart <= 1'b0;
      qstart <= 1'b0;
    end else begin
      bwe <= 1'b0;
      swe <= 1'b0;
      dstart <= 1'b0;
      qstart <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_CLR: begin
          swe <= 1'b1;
          swaddr <= clr_cnt;
          stg <= '0; sn <= '0;
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == NUM_CONTACTS - 1) st <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd <= command;
            ia <= BW'(32'(body_a) % NUM_BODIES);
            ib <= BW'(32'(body_b) % NUM_BODIES);
            is <= SW'(32'(contact_slot) % NUM_CONTACTS);
            braddr <= BW'(32'(body_a) % NUM_BODIES);
            sraddr <= SW'(32'(contact_slot) % NUM_CONTACTS);
            v1 <= value_one; v2 <= value_two; v3 <= value_three;
            v4 <= value_four; v5 <= value_five; v6 <= value_six;
            st <= S_RDA;
          end
        end
        S_RDA: begin
          braddr <= ib;
          st <= S_RDB;
        end
        S_RDB: begin
          for (int i = 0; i < NF; i++) ba[i] <= brd[i*32 +: 32];
          sn <= srd[31:0]; stg <= srd[63:32];
          st <= S_RDW;
        end
        S_RDW: begin
          for (int i = 0; i < NF; i++) bb[i] <= brd[i*32 +: 32];
          case (cmd)
            CMD_LOAD_MASS: begin
              ba[F_IM] <= v1; ba[F_II] <= v2; ba[F_FR] <= v3;
              ba[F_CX] <= v4; ba[F_CY] <= v5; st <= S_WRB;
            end
            CMD_LOAD_MOT: begin
              ba[F_PX] <= v1; ba[F_PY] <= v2; ba[F_AN] <= v3;
              ba[F_VX] <= v4; ba[F_VY] <= v5; ba[F_W] <= v6; st <= S_WRB;
            end
            CMD_CLEAR: begin
              sn <= '0; stg <= '0; swe <= 1'b1; swaddr <= is; st <= S_OUT;
            end
            CMD_SOLVE: begin
              if (samebody) for (int i = 0; i < NF; i++) bb[i] <= brd[i*32 +: 32];
              st <= S_CALC; step <= 7'd100; phase_t <= 1'b0;
              dx <= v3; dy <= v4;
            end
            default: st <= S_OUT;
          endcase
        end
        S_CALC: begin
          step <= step + 7'd1;
          case (step)
            7'd100: begin
              rax <= qsub(v1, qadd(ba[F_PX], ba[F_CX]));
              ray <= qsub(v2, qadd(ba[F_PY], ba[F_CY]));
              rbx <= qsub(v1, qadd(bb[F_PX], bb[F_CX]));
              rby <= qsub(v2, qadd(bb[F_PY], bb[F_CY]));
              tm <= qadd(ba[F_IM], bb[F_IM]);
              step <= 7'd0;
            end
            7'd0: svx <= qsub(ba[F_VX], mp);
            7'd1: svx <= qadd(qsub(svx, bb[F_VX]), mp);
            7'd2: svy <= qadd(ba[F_VY], mp);
            7'd3: svy <= qsub(qsub(svy, bb[F_VY]), mp);
            7'd4: t0 <= mp;
            7'd5: vn <= qadd(t0, mp);
            7'd6: t0 <= mp;
            7'd7: ca <= qsub(t0, mp);
            7'd8: t0 <= mp;
            7'd9: cb <= qsub(t0, mp);
            7'd10: t0 <= mp;
            7'd11: t0 <= mp;
            7'd12: t1 <= mp;
            7'd13: begin
              kk <= qadd(tm, qadd(t0, mp));
              dstart <= 1'b1;
              st <= S_DIVW;
            end
            default: ;
          endcase
        end
        S_DIVW: begin
          st <= S_DIV;
        end
        S_DIV: begin
          if (ddone) begin
            if (!phase_t) begin
              t0 <= qadd(sn, (kk == 0) ? 32'sd0 : dquo);
              step <= 7'd120;
              st <= S_APPLY;
              ap <= 4'd15;
            end else begin
              t0 <= qadd(stg, (kk == 0) ? 32'sd0 : dquo);
              st <= S_APPLY;
              ap <= 4'd14;
            end
          end
        end
        S_SQRT: begin
          if (qdone) begin
            fr <= qroot;
            phase_t <= 1'b1;
            dx <= v4;
            dy <= qneg(v3);
            step <= 7'd4;
            st <= S_CALC;
          end
        end
        S_SQW: st <= S_SQRT;
        S_APPLY: begin
          ap <= ap + 4'd1;
          case (ap)
            4'd15: begin
              // normal clamp
              if (t0 < 0) begin sn <= '0; lam <= qsub(32'sd0, sn); nl <= qneg(qsub(32'sd0, sn)); end
              else begin sn <= t0; lam <= qsub(t0, sn); nl <= qneg(qsub(t0, sn)); end
              onb <= 1'b0;
              ap <= 4'd0;
            end
            4'd14: begin
              maxf <= qmul(fr, sn);
              ap <= 4'd13;
            end
            4'd13: begin
              lam <= qsub(tcl, stg);
              nl <= qneg(qsub(tcl, stg));
              stg <= tcl;
              onb <= 1'b0;
              ap <= 4'd0;
            end
            4'd0, 4'd2, 4'd4: t0 <= ap_m;
            4'd1: ix <= ap_m;
            4'd3: iy <= ap_m;
            4'd5: ig <= ap_m;
            4'd6: t1 <= ap_m;
            4'd7: begin
              if (!onb) begin
                ba[F_PX] <= qadd(ba[F_PX], t1);
                ba[F_VX] <= qadd(ba[F_VX], ix);
                ba[F_VY] <= qadd(ba[F_VY], iy);
                ba[F_W]  <= qadd(ba[F_W], ig);
                ba[F_PY] <= qadd(ba[F_PY], ap_m);
              end else begin
                bb[F_PX] <= qadd(bb[F_PX], t1);
                bb[F_VX] <= qadd(bb[F_VX], ix);
                bb[F_VY] <= qadd(bb[F_VY], iy);
                bb[F_W]  <= qadd(bb[F_W], ig);
                bb[F_PY] <= qadd(bb[F_PY], ap_m);
              end
            end
            4'd8: begin
              if (!onb) begin
                ba[F_AN] <= qadd(ba[F_AN], ap_m);
                if (samebody) begin
                  bb[F_PX] <= ba[F_PX]; bb[F_PY] <= ba[F_PY];
                  bb[F_VX] <= ba[F_VX]; bb[F_VY] <= ba[F_VY];
                  bb[F_W] <= ba[F_W]; bb[F_AN] <= qadd(ba[F_AN], ap_m);
                end
                onb <= 1'b1;
                ap <= 4'd0;
              end else begin
                bb[F_AN] <= qadd(bb[F_AN], ap_m);
                if (samebody) begin
                  ba[F_PX] <= bb[F_PX]; ba[F_PY] <= bb[F_PY];
                  ba[F_VX] <= bb[F_VX]; ba[F_VY] <= bb[F_VY];
                  ba[F_W] <= bb[F_W]; ba[F_AN] <= qadd(bb[F_AN], ap_m);
                end
                if (!phase_t && ba[F_FR] > 0 && bb[F_FR] > 0) begin
                  t0 <= qmul(ba[F_FR], bb[F_FR]);
                  qstart <= 1'b1;
                  st <= S_SQW;
                end else begin
                  st <= S_WRB;
                  swe <= 1'b1;
                  swaddr <= is;
                end
              end
            end
            default: ;
          endcase
        end
        S_WRB: begin
          if (cmd == CMD_SOLVE && !samebody) begin
            bwe <= 1'b1;
            bwaddr <= ib;
            for (int i = 0; i < NF; i++) ba[i] <= bb[i];
            bb <= ba;
            st <= S_OUTW;
          end else begin
            bwe <= 1'b1;
            bwaddr <= ia;
            st <= S_OUT;
          end
        end
        S_OUTW: begin
          bwe <= 1'b1;
          bwaddr <= ia;
          ba <= bb;
          st <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            pos_x <= ba[F_PX]; pos_y <= ba[F_PY]; angle <= ba[F_AN];
            speed_x <= ba[F_VX]; speed_y <= ba[F_VY]; spin <= ba[F_W];
            normal_impulse <= sn[30:0];
            tangent_impulse <= stg;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(pos_x) && $stable(tangent_impulse)))
    else $error("result changed while stalled");
endmodule

FILE: verif/cis2d_checker.sv
`timescale 1ns / 1ps

module cis2d_checker
  import cis2d_pkg::*;
#(
  parameter logic [1:0] TS_ADDR = 2'd0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         command,
  input  logic [5:0]         body_a,
  input  logic [5:0]         body_b,
  input  logic [5:0]         contact_slot,
  input  logic signed [31:0] value_one,
  input  logic signed [31:0] value_two,
  input  logic signed [31:0] value_three,
  input  logic signed [31:0] value_four,
  input  logic signed [31:0] value_five,
  input  logic signed [31:0] value_six,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] angle,
  input  logic signed [31:0] speed_x,
  input  logic signed [31:0] speed_y,
  input  logic signed [31:0] spin,
  input  logic [30:0]        normal_impulse,
  input  logic signed [31:0] tangent_impulse,
  output int                 errors,
  output int                 pending,
  output int                 solves_seen
);

  typedef struct packed {
    logic signed [31:0] px, py, ang, vx, vy, w;
    logic [30:0]        ni;
    logic signed [31:0] ti;
  } body_report_t;

  body_report_t expected_reports[$];

  logic [30:0] step_size;
  int bpx[64], bpy[64], bang[64], bvx[64], bvy[64], bw[64];
  int inv_m[64], inv_i[64], fric[64], cx[64], cy[64];
  int acc_n[64], acc_t[64];

  function automatic int clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int fx_add(int a, int b);
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic int fx_sub(int a, int b);
    return clip(longint'(a) - longint'(b));
  endfunction

  function automatic int fx_neg(int a);
    return clip(-longint'(a));
  endfunction

  function automatic int fx_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    if (p >= 0) return clip(p >>> 16);
    return clip(-((-p + 64'sd65535) >>> 16));
  endfunction

  function automatic int fx_ratio(int v, int k);
    if (k == 0) return 0;
    return clip((-longint'(v) * 64'sd65536) / longint'(k));
  endfunction

  function automatic int fx_root(int x);
    longint unsigned v, res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    if (x <= 0) return 0;
    v = longint'(x) << 16;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return clip(longint'(res));
  endfunction

  function automatic int fx_cross(int rx, int ry, int dx, int dy);
    return fx_sub(fx_mul(rx, dy), fx_mul(ry, dx));
  endfunction

  task automatic nudge(int i, int ix, int iy, int dw);
    int dt;
    dt = int'({1'b0, step_size});
    bpx[i] = fx_add(bpx[i], fx_mul(ix, dt));
    bpy[i] = fx_add(bpy[i], fx_mul(iy, dt));
    bang[i] = fx_add(bang[i], fx_mul(dw, dt));
    bvx[i] = fx_add(bvx[i], ix);
    bvy[i] = fx_add(bvy[i], iy);
    bw[i] = fx_add(bw[i], dw);
  endtask

  task automatic kick(int a, int b, int lam, int dx, int dy, int ca, int cb);
    int nl;
    nl = fx_neg(lam);
    nudge(a, fx_mul(fx_mul(lam, dx), inv_m[a]), fx_mul(fx_mul(lam, dy), inv_m[a]),
          fx_mul(fx_mul(lam, ca), inv_i[a]));
    nudge(b, fx_mul(fx_mul(nl, dx), inv_m[b]), fx_mul(fx_mul(nl, dy), inv_m[b]),
          fx_mul(fx_mul(nl, cb), inv_i[b]));
  endtask

  task automatic resolve_contact(int a, int b, int s, int qx, int qy, int nx, int ny);
    int rax, ray, rbx, rby, svx, svy, tmass, vn, ca, cb, k, lam, acc, nimp;
    int f, tx, ty, vt, cta, ctb, kt, lt, maxf, tacc, nt;
    rax = fx_sub(qx, fx_add(bpx[a], cx[a]));
    ray = fx_sub(qy, fx_add(bpy[a], cy[a]));
    rbx = fx_sub(qx, fx_add(bpx[b], cx[b]));
    rby = fx_sub(qy, fx_add(bpy[b], cy[b]));
    svx = fx_sub(bvx[a], fx_mul(ray, bw[a]));
    svx = fx_sub(svx, bvx[b]);
    svx = fx_add(svx, fx_mul(rby, bw[b]));
    svy = fx_add(bvy[a], fx_mul(rax, bw[a]));
    svy = fx_sub(svy, bvy[b]);
    svy = fx_sub(svy, fx_mul(rbx, bw[b]));
    tmass = fx_add(inv_m[a], inv_m[b]);
    vn = fx_add(fx_mul(svx, nx), fx_mul(svy, ny));
    ca = fx_cross(rax, ray, nx, ny);
    cb = fx_cross(rbx, rby, nx, ny);
    k = fx_add(tmass, fx_add(fx_mul(inv_i[a], fx_mul(ca, ca)),
                             fx_mul(inv_i[b], fx_mul(cb, cb))));
    lam = fx_ratio(vn, k);
    acc = acc_n[s];
    nimp = fx_add(acc, lam);
    if (nimp < 0) nimp = 0;
    lam = fx_sub(nimp, acc);
    acc_n[s] = nimp;
    kick(a, b, lam, nx, ny, ca, cb);
    if (fric[a] > 0 && fric[b] > 0) begin
      f = fx_root(fx_mul(fric[a], fric[b]));
      tx = ny;
      ty = fx_neg(nx);
      vt = fx_add(fx_mul(svx, tx), fx_mul(svy, ty));
      cta = fx_cross(rax, ray, tx, ty);
      ctb = fx_cross(rbx, rby, tx, ty);
      kt = fx_add(tmass, fx_add(fx_mul(inv_i[a], fx_mul(cta, cta)),
                                fx_mul(inv_i[b], fx_mul(ctb, ctb))));
      lt = fx_ratio(vt, kt);
      maxf = fx_mul(f, acc_n[s]);
      tacc = acc_t[s];
      nt = fx_add(tacc, lt);
      if (nt > maxf) nt = maxf;
      if (nt < fx_neg(maxf)) nt = fx_neg(maxf);
      lt = fx_sub(nt, tacc);
      acc_t[s] = nt;
      kick(a, b, lt, tx, ty, cta, ctb);
    end
  endtask

  task automatic predict_request();
    int a, s;
    body_report_t r;
    a = body_a;
    s = contact_slot;
    case (command)
      CMD_LOAD_MASS: begin
        inv_m[a] = value_one; inv_i[a] = value_two; fric[a] = value_three;
        cx[a] = value_four; cy[a] = value_five;
      end
      CMD_LOAD_MOT: begin
        bpx[a] = value_one; bpy[a] = value_two; bang[a] = value_three;
        bvx[a] = value_four; bvy[a] = value_five; bw[a] = value_six;
      end
      CMD_CLEAR: begin
        acc_n[s] = 0; acc_t[s] = 0;
      end
      CMD_SOLVE: begin
        resolve_contact(a, body_b, s, value_one, value_two, value_three, value_four);
        solves_seen++;
      end
      default: ;
    endcase
    r.px = bpx[a]; r.py = bpy[a]; r.ang = bang[a];
    r.vx = bvx[a]; r.vy = bvy[a]; r.w = bw[a];
    r.ni = acc_n[s][30:0]; r.ti = acc_t[s];
    expected_reports.push_back(r);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    solves_seen = 0;
    step_size = TIME_STEP_RESET;
    for (int i = 0; i < 64; i++) begin
      acc_n[i] = 0; acc_t[i] = 0;
    end
  end

  always @(posedge clk) begin
    body_report_t e;
    if (rst) begin
      step_size = TIME_STEP_RESET;
      for (int i = 0; i < 64; i++) begin
        acc_n[i] = 0; acc_t[i] = 0;
      end
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TS_ADDR)
        step_size = pwdata[30:0];
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("unexpected result");
          errors++;
        end else begin
          e = expected_reports.pop_front();
          if (pos_x !== e.px) report("pos_x", pos_x, e.px);
          if (pos_y !== e.py) report("pos_y", pos_y, e.py);
          if (angle !== e.ang) report("angle", angle, e.ang);
          if (speed_x !== e.vx) report("speed_x", speed_x, e.vx);
          if (speed_y !== e.vy) report("speed_y", speed_y, e.vy);
          if (spin !== e.w) report("spin", spin, e.w);
          if (normal_impulse !== e.ni) report("normal_impulse", normal_impulse, e.ni);
          if (tangent_impulse !== e.ti) report("tangent_impulse", tangent_impulse, e.ti);
        end
      end
      if (in_valid && in_ready) predict_request();
    end
    pending = expected_reports.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import cis2d_pkg::*;

  localparam logic [2:0] CMD_SPARE = 3'd5;
  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] command = '0;
  logic [5:0] body_a = '0, body_b = '0, contact_slot = '0;
  logic signed [31:0] value_one = 0, value_two = 0, value_three = 0;
  logic signed [31:0] value_four = 0, value_five = 0, value_six = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] pos_x, pos_y, angle, speed_x, speed_y, spin, tangent_impulse;
  logic [30:0] normal_impulse;
  int errors, pending, solves_seen;
  int cycles = 0;
  int requests_sent = 0;
  bit quiet = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  contact_impulse_solver_2d u_top (.*);

  cis2d_checker #(.TS_ADDR(REG_TIME_STEP)) u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 20);

  function automatic int span(int units);
    return int'($urandom_range(0, 2 * units * ONE)) - units * ONE;
  endfunction

  task automatic send(logic [2:0] c, int a, int b, int s,
                      int v1, int v2, int v3, int v4, int v5, int v6);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1;
    command = c; body_a = 6'(a); body_b = 6'(b); contact_slot = 6'(s);
    value_one = v1; value_two = v2; value_three = v3;
    value_four = v4; value_five = v5; value_six = v6;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    requests_sent++;
  endtask

  task automatic set_time_step(logic [30:0] ts);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    psel = 1; pwrite = 1; paddr = REG_TIME_STEP; pwdata = {1'b0, ts}; penable = 0;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic load_motion(int i);
    send(CMD_LOAD_MOT, i, $urandom, $urandom, span(20), span(20), span(4),
         span(5), span(5), span(2));
  endtask

  task automatic load_mass(int i);
    send(CMD_LOAD_MASS, i, $urandom, $urandom, $urandom_range(0, 2 * ONE),
         $urandom_range(0, 2 * ONE), int'($urandom_range(0, ONE + ONE / 4)) - ONE / 4,
         span(1), span(1), $urandom);
  endtask

  task automatic random_request();
    int r, nx, ny;
    r = $urandom_range(99);
    nx = span(1);
    ny = span(1);
    if (r < 62)
      send(CMD_SOLVE, $urandom_range(63), $urandom_range(63), $urandom_range(15),
           span(20), span(20), nx, ny, $urandom, $urandom);
    else if (r < 70) load_motion($urandom_range(63));
    else if (r < 77) load_mass($urandom_range(63));
    else if (r < 84)
      send(CMD_CLEAR, $urandom_range(63), $urandom, $urandom_range(63),
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 91)
      send(CMD_READ, $urandom_range(63), $urandom, $urandom_range(63),
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 94)
      send(3'($urandom_range(CMD_SPARE, 7)), $urandom_range(63), $urandom,
           $urandom_range(63), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
    else if (r < 97)
      send(CMD_SOLVE, $urandom_range(63), $urandom_range(63), $urandom_range(63),
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send(CMD_LOAD_MOT, $urandom_range(63), $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [30:0] steps[4];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // every body gets motion and mass before any use
    for (int i = 0; i < 64; i++) begin
      load_motion(i);
      load_mass(i);
    end

    // directed cases at the reset time step
    send(CMD_SOLVE, 0, 1, 0, 0, 0, 0, ONE, 0, 0);
    send(CMD_SOLVE, 0, 1, 0, 0, 0, 0, ONE, 0, 0);
    send(CMD_SOLVE, 2, 2, 1, ONE, -ONE, ONE, 0, 0, 0);
    send(CMD_LOAD_MASS, 3, 0, 0, 0, 0, ONE, 0, 0, 0);
    send(CMD_LOAD_MASS, 4, 0, 0, 0, 0, ONE, 0, 0, 0);
    send(CMD_SOLVE, 3, 4, 2, ONE, ONE, 0, -ONE, 0, 0);
    send(CMD_LOAD_MASS, 5, 0, 0, ONE, ONE, -ONE, 0, 0, 0);
    send(CMD_SOLVE, 5, 6, 3, 0, ONE, -ONE, 0, 0, 0);
    send(CMD_LOAD_MOT, 7, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(CMD_LOAD_MASS, 7, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
         32'sh80000000, 32'sh7fffffff, 0);
    send(CMD_LOAD_MASS, 8, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
         32'sh7fffffff, 32'sh80000000, 0);
    send(CMD_SOLVE, 7, 8, 63, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
         32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send(CMD_SOLVE, 8, 7, 63, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
         32'sh7fffffff, 0, 0);
    send(CMD_READ, 63, 63, 63, 0, 0, 0, 0, 0, 0);
    send(CMD_CLEAR, 63, 0, 63, 0, 0, 0, 0, 0, 0);
    send(CMD_READ, 0, 0, 0, -1, -1, -1, -1, -1, -1);
    for (int c = CMD_SPARE; c < 8; c++)
      send(3'(c), 1, 63, 1, 0, 0, 0, 0, 0, 0);

    steps[0] = 31'd0;
    steps[1] = 31'h7fffffff;
    steps[2] = 31'($urandom_range(1, 4000));
    steps[3] = TIME_STEP_RESET;
    for (int p = 0; p < 4; p++) begin
      set_time_step(steps[p]);
      if (p == 0) begin
        for (int i = 0; i < 64; i++) load_motion(i);
      end
      quiet = (p == 2);
      for (int n = 0; n < 75; n++) random_request();
      quiet = 0;
    end

    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("requests sent: %0d, contacts solved: %0d", requests_sent, solves_seen);
    $display("time steps: zero, full scale, random, reset value");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
